// ===== hw/rtl/circular_deque_with_delete_macros.svh =====
// assertion macros shared by the deque checker
`ifndef CIRCULAR_DEQUE_WITH_DELETE_MACROS_SVH
`define CIRCULAR_DEQUE_WITH_DELETE_MACROS_SVH

// checked on every edge outside reset
`define CDQD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define CDQD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/cdqd_pkg.sv =====
// types and codes shared by the deque cells, top level and checker
`default_nettype none

package cdqd_pkg;

  localparam int ValueW = 32;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_DELETE     = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [4:0] {
    C_NONE       = 5'b00001,
    C_SHIFT_UP   = 5'b00010,
    C_LOAD_BACK  = 5'b00100,
    C_SHIFT_DOWN = 5'b01000,
    C_DELETE     = 5'b10000
  } cell_op_t;

  typedef struct packed {
    cell_op_t                   op;
    logic signed [ValueW-1:0]   val;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cdqd_cell.sv =====
// one deque position: holds an entry, takes from a neighbour on shifts
`default_nettype none

module cdqd_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  wire logic                          clk,
  input  wire cdqd_pkg::cell_cmd_t           cmd,
  input  wire logic [CNT_W-1:0]              count,
  input  wire logic signed [cdqd_pkg::ValueW-1:0] prev_data,
  input  wire logic signed [cdqd_pkg::ValueW-1:0] next_data,
  input  wire logic                          hit_in,
  input  wire logic [cdqd_pkg::ValueW-1:0]   back_in,
  output logic signed [cdqd_pkg::ValueW-1:0] data,
  output logic                               hit_out,
  output logic [cdqd_pkg::ValueW-1:0]        back_out
);
  import cdqd_pkg::*;

  logic occ;
  logic is_slot;
  logic is_tail;

  assign occ      = CNT_W'(IDX) < count;
  assign is_slot  = CNT_W'(IDX) == count;
  assign is_tail  = CNT_W'(IDX + 1) == count;
  // first match from the front: every cell from the hit onward closes the gap
  assign hit_out  = hit_in | (occ & (data == cmd.val));
  assign back_out = back_in | (is_tail ? data : '0);

  always_ff @(posedge clk) begin
    case (cmd.op)
      C_SHIFT_UP:   data <= prev_data;
      C_LOAD_BACK:  if (is_slot) data <= cmd.val;
      C_SHIFT_DOWN: data <= next_data;
      C_DELETE:     if (hit_out) data <= next_data;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/circular_deque_with_delete.sv =====
// bounded deque of signed words with delete by value, built as a row of cells
//
// Request channel: opcode and item_value, one beat per operation (push front,
// push back, pop front, pop back, delete first match from the front).
// Response channel: status, entry_count, front_value and back_value, one beat
// per request; front and back read zero when the deque is empty.
// Every operation, delete included, updates the cell row at the edge that
// accepts it: front pushes and pops shift all cells, push back loads the slot
// cell, pop back only lowers the count, and delete shifts the cells from the
// first match onward; the first-match flag ripples from the front cell to the back cell.
// The response is registered from the updated cells in the following cycle;
// while a request is pending, req_stall is high and no new request is taken.
// Reset empties the deque and drops any pending response; cell contents are
// not cleared, only the count.
// While the receiver stalls a waiting response, req_stall stays high and no
// further request is taken; the response holds until it is taken.
`default_nettype none

module circular_deque_with_delete #(
  parameter int CAPACITY = 16,
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 req_valid,
  output logic                                      req_stall,
  input  wire logic [2:0]                           opcode,
  input  wire logic signed [cdqd_pkg::ValueW-1:0]   item_value,
  output logic                                      rsp_valid,
  input  wire logic                                 rsp_stall,
  output logic [1:0]                                status,
  output logic [CNT_W-1:0]                          entry_count,
  output logic signed [cdqd_pkg::ValueW-1:0]        front_value,
  output logic signed [cdqd_pkg::ValueW-1:0]        back_value
);
  import cdqd_pkg::*;

  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] fill_count_next;
  logic             pend;
  logic [1:0]       res_status;
  logic [1:0]       res_status_next;
  logic [CNT_W-1:0] res_count;

  logic             accept;
  logic             full;
  logic             empty;
  logic             found;
  cell_cmd_t        cmd;

  logic signed [ValueW-1:0] cell_data [CAPACITY];
  logic                     hit   [CAPACITY+1];
  logic [ValueW-1:0]        back  [CAPACITY+1];

  assign req_stall = pend | (rsp_valid & rsp_stall);
  assign accept    = req_valid & ~req_stall;
  assign full      = fill_count == CNT_W'(CAPACITY);
  assign empty     = fill_count == '0;
  assign found     = hit[CAPACITY];
  assign hit[0]    = 1'b0;
  assign back[0]   = '0;

  always_comb begin
    cmd.val         = item_value;
    cmd.op          = C_NONE;
    res_status_next = ST_OK;
    fill_count_next = fill_count;
    case (opcode)
      OP_PUSH_FRONT: begin
        if (full) begin
          res_status_next = ST_FULL;
        end else begin
          cmd.op          = C_SHIFT_UP;
          fill_count_next = fill_count + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          res_status_next = ST_FULL;
        end else begin
          cmd.op          = C_LOAD_BACK;
          fill_count_next = fill_count + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          res_status_next = ST_EMPTY;
        end else begin
          cmd.op          = C_SHIFT_DOWN;
          fill_count_next = fill_count - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          res_status_next = ST_EMPTY;
        end else begin
          fill_count_next = fill_count - 1'b1;
        end
      end
      OP_DELETE: begin
        if (empty) begin
          res_status_next = ST_EMPTY;
        end else if (!found) begin
          res_status_next = ST_NOTFOUND;
        end else begin
          cmd.op          = C_DELETE;
          fill_count_next = fill_count - 1'b1;
        end
      end
      default: ;
    endcase
    if (!accept) begin
      cmd.op          = C_NONE;
      fill_count_next = fill_count;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [ValueW-1:0] prev_d;
    logic signed [ValueW-1:0] next_d;

    // the front cell takes the pushed value, the back cell takes zero
    if (i == 0) begin : g_front
      assign prev_d = item_value;
    end else begin : g_mid
      assign prev_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_back
      assign next_d = '0;
    end else begin : g_inner
      assign next_d = cell_data[i+1];
    end

    cdqd_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .count     (fill_count),
      .prev_data (prev_d),
      .next_data (next_d),
      .hit_in    (hit[i]),
      .back_in   (back[i]),
      .data      (cell_data[i]),
      .hit_out   (hit[i+1]),
      .back_out  (back[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      pend       <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      fill_count <= fill_count_next;
      pend       <= accept;
      if (pend) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_status <= res_status_next;
      res_count  <= fill_count_next;
    end
    if (pend) begin
      status      <= res_status;
      entry_count <= res_count;
      front_value <= (fill_count != '0) ? cell_data[0] : '0;
      back_value  <= back[CAPACITY];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cdqd_checker.sv =====
// port-level checks on the deque, bound to the top level
`default_nettype none
`include "circular_deque_with_delete_macros.svh"

module cdqd_checker #(
  parameter int CAPACITY = 16,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               req_valid,
  input wire logic                               req_stall,
  input wire logic                               rsp_valid,
  input wire logic                               rsp_stall,
  input wire logic [1:0]                         status,
  input wire logic [CNT_W-1:0]                   entry_count,
  input wire logic signed [cdqd_pkg::ValueW-1:0] front_value,
  input wire logic signed [cdqd_pkg::ValueW-1:0] back_value
);
  import cdqd_pkg::*;

  `CDQD_ASSERT_ALWAYS(a_rst_clears_rsp, rst |=> !rsp_valid, "response valid after reset")

  `CDQD_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(entry_count) && $stable(front_value) && $stable(back_value), "stalled response changed")

  `CDQD_ASSERT(a_req_latency, req_valid && !req_stall |=> req_stall ##1 rsp_valid, "response not two cycles after request")

  `CDQD_ASSERT(a_full_count, rsp_valid && status == ST_FULL |-> entry_count == CNT_W'(CAPACITY), "full status with deque not full")

  `CDQD_ASSERT(a_empty_zero, rsp_valid && entry_count == '0 |-> front_value == '0 && back_value == '0, "empty deque reports nonzero ends")

endmodule

bind circular_deque_with_delete cdqd_checker #(
  .CAPACITY (CAPACITY),
  .CNT_W    (CNT_W)
) u_cdqd_checker (.*);

`default_nettype wire
